@@ src/clrs_pkg.sv @@
// Shared types, constants and helper functions for the character LCD refresh sequencer.
package clrs_pkg;

	// Default geometry of the display.
	localparam int ROWS_DEFAULT    = 2;
	localparam int COLUMNS_DEFAULT = 16;

	// Command address field covers the largest store (2 rows by 40 columns).
	localparam int CMD_ADDR_W = 7;

	// Depth of the command queue between the front and back ends.
	localparam int QUEUE_DEPTH = 4;

	// LCD bus constants.
	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] ROW1_OFFSET  = 8'h40;
	localparam logic [7:0] SPACE_CHAR   = 8'h20;
	localparam logic [2:0] INIT_LEN     = 3'd6;

	// Reset value of the refresh period register.
	localparam logic [15:0] PERIOD_RESET = 16'd1;

	// Input opcodes.
	typedef enum logic [1:0] {
		OP_WRITE_CHAR = 2'd0,
		OP_TICK       = 2'd1,
		OP_INIT       = 2'd2,
		OP_SET_CURSOR = 2'd3
	} op_t;

	// Commands handed from the front end to the back end.
	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_INIT    = 2'd1,
		CMD_CURSOR  = 2'd2,
		CMD_REFRESH = 2'd3
	} cmd_op_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		SEQ_IDLE   = 2'd0,
		SEQ_INIT   = 2'd1,
		SEQ_ROWCMD = 2'd2,
		SEQ_DATA   = 2'd3
	} seq_state_t;

	// One input beat.
	typedef struct packed {
		op_t        opcode;
		logic       row;
		logic [3:0] column;
		logic [7:0] char_code;
	} in_item_t;

	// One output beat (one LCD bus write).
	typedef struct packed {
		logic       reg_select;
		logic [7:0] bus_byte;
		logic       last;
	} out_item_t;

	// One queued command.
	typedef struct packed {
		cmd_op_t               op;
		logic [CMD_ADDR_W-1:0] addr;
		logic [7:0]            data;
	} cmd_t;

	// A bus write in flight inside the back end; store bytes are filled in later.
	typedef struct packed {
		logic       reg_select;
		logic [7:0] bus_byte;
		logic       from_store;
		logic       last;
	} beat_t;

	// Controller setup sequence.
	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h38;
			3'd1: b = 8'h0C;
			3'd2: b = 8'h01;
			3'd3: b = 8'h06;
			3'd4: b = 8'h14;
			3'd5: b = 8'h80;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ src/clrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module clrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/clrs_queue.sv @@
// Small command queue between the front end and the back end.
module clrs_queue #(
	parameter int DEPTH = clrs_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clrs_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output clrs_pkg::cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	clrs_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// The count never runs past the depth, and a pop on an empty queue changes nothing.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("command queue count exceeds depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !not_empty && !push) |=> $stable(rptr_q) && (count_q == '0))
		else $error("pop on empty queue moved the read pointer");

endmodule

@@ src/clrs_front.sv @@
// Front end: accepts input beats, runs the tick counter and dirty flag, queues commands.
module clrs_front #(
	parameter int ROWS    = clrs_pkg::ROWS_DEFAULT,
	parameter int COLUMNS = clrs_pkg::COLUMNS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  clrs_pkg::in_item_t in_data,
	input  logic [15:0]       refresh_period,
	input  logic              q_full,
	output logic              push,
	output clrs_pkg::cmd_t    push_cmd
);

	localparam int AW = clrs_pkg::CMD_ADDR_W;

	logic [15:0] tick_cnt_q;
	logic        dirty_q;
	logic        in_fire;
	logic        in_range;
	logic [15:0] tick_next;
	logic        period_hit;
	logic [7:0]  cursor_byte;

	assign in_stall = q_full;
	assign in_fire  = in_valid && !q_full;

	// Classification of the current beat.
	assign in_range    = (32'(in_data.row) < ROWS) && (32'(in_data.column) < COLUMNS);
	assign tick_next   = tick_cnt_q + 16'd1;
	assign period_hit  = (tick_next >= refresh_period);
	assign cursor_byte = clrs_pkg::CMD_SET_ADDR + (in_data.row ? clrs_pkg::ROW1_OFFSET : 8'h00)
		+ {4'h0, in_data.column};

	// Command to queue for the accepted beat.
	always_comb begin
		push          = 1'b0;
		push_cmd.op   = clrs_pkg::CMD_WRITE;
		push_cmd.addr = AW'(in_data.row ? COLUMNS : 0) + AW'(in_data.column);
		push_cmd.data = in_data.char_code;
		case (in_data.opcode)
			clrs_pkg::OP_WRITE_CHAR: begin
				push = in_fire && in_range;
			end
			clrs_pkg::OP_TICK: begin
				push_cmd.op = clrs_pkg::CMD_REFRESH;
				push        = in_fire && period_hit && dirty_q;
			end
			clrs_pkg::OP_INIT: begin
				push_cmd.op = clrs_pkg::CMD_INIT;
				push        = in_fire;
			end
			clrs_pkg::OP_SET_CURSOR: begin
				push_cmd.op   = clrs_pkg::CMD_CURSOR;
				push_cmd.data = cursor_byte;
				push          = in_fire;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Tick counter and dirty flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q <= '0;
			dirty_q    <= 1'b0;
		end else if (in_fire) begin
			if (in_data.opcode == clrs_pkg::OP_TICK) begin
				tick_cnt_q <= period_hit ? 16'd0 : tick_next;
				if (period_hit) begin
					dirty_q <= 1'b0;
				end
			end else if (in_data.opcode == clrs_pkg::OP_WRITE_CHAR && in_range) begin
				dirty_q <= 1'b1;
			end
		end
	end

	// A queued refresh always leaves a clean store, and only a dirty store is refreshed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_cmd.op == clrs_pkg::CMD_REFRESH) |=> !dirty_q)
		else $error("dirty flag still set after refresh was queued");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_cmd.op == clrs_pkg::CMD_REFRESH) |-> dirty_q && !q_full)
		else $error("refresh queued for a clean store or into a full queue");

endmodule

@@ src/clrs_back.sv @@
// Back end: executes queued commands, reads the frame store and drives the LCD bus beats.
module clrs_back #(
	parameter int ROWS    = clrs_pkg::ROWS_DEFAULT,
	parameter int COLUMNS = clrs_pkg::COLUMNS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  clrs_pkg::cmd_t      q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output clrs_pkg::out_item_t out_data
);

	localparam int DEPTH = ROWS * COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

	clrs_pkg::seq_state_t state_q;
	clrs_pkg::seq_state_t state_d;
	logic [2:0]           idx_q;
	logic [2:0]           idx_d;
	logic [CW-1:0]        col_q;
	logic [CW-1:0]        col_d;
	logic [RW-1:0]        row_q;
	logic [RW-1:0]        row_d;

	logic                 gen_valid;
	clrs_pkg::beat_t      gen_beat;
	logic [AW-1:0]        gen_addr;
	logic                 gen_fire;
	logic                 col_last;
	logic                 row_last;

	logic                 ram_we;
	logic [AW-1:0]        rd_addr;
	logic [7:0]           ram_rdata;
	logic [DEPTH-1:0]     valid_q;

	logic                 valid_s1;
	clrs_pkg::beat_t      beat_s1;
	logic [AW-1:0]        addr_s1;
	logic                 s1_ready;
	logic                 s1_adv;

	logic                 out_valid_q;
	clrs_pkg::out_item_t  out_q;
	clrs_pkg::out_item_t  out_next;
	logic                 ended_q;
	logic                 ended_d;
	logic [7:0]           store_byte;

	assign col_last = (col_q == CW'(COLUMNS - 1));
	assign row_last = (row_q == RW'(ROWS - 1));
	assign gen_addr = ((row_q == RW'(1)) ? AW'(COLUMNS) : AW'(0)) + AW'(col_q);
	assign gen_fire = gen_valid && s1_ready;

	// Beat generation and command pops for the current state.
	always_comb begin
		gen_valid = 1'b0;
		gen_beat  = '0;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		case (state_q)
			clrs_pkg::SEQ_IDLE: begin
				if (q_not_empty) begin
					case (q_head.op)
						clrs_pkg::CMD_WRITE: begin
							// A held store beat rereads its address, so the write waits for it.
							ram_we = s1_ready;
							q_pop  = s1_ready;
						end
						clrs_pkg::CMD_CURSOR: begin
							gen_valid         = 1'b1;
							gen_beat.bus_byte = q_head.data;
							gen_beat.last     = 1'b1;
							q_pop             = s1_ready;
						end
						clrs_pkg::CMD_INIT: begin
							gen_valid         = 1'b1;
							gen_beat.bus_byte = clrs_pkg::init_byte(3'd0);
							q_pop             = s1_ready;
						end
						clrs_pkg::CMD_REFRESH: begin
							gen_valid         = 1'b1;
							gen_beat.bus_byte = clrs_pkg::CMD_SET_ADDR;
							q_pop             = s1_ready;
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			clrs_pkg::SEQ_INIT: begin
				gen_valid         = 1'b1;
				gen_beat.bus_byte = clrs_pkg::init_byte(idx_q);
				gen_beat.last     = (idx_q == clrs_pkg::INIT_LEN - 3'd1);
			end
			clrs_pkg::SEQ_ROWCMD: begin
				gen_valid         = 1'b1;
				gen_beat.bus_byte = clrs_pkg::CMD_SET_ADDR
					| ((row_q == RW'(1)) ? clrs_pkg::ROW1_OFFSET : 8'h00);
			end
			clrs_pkg::SEQ_DATA: begin
				gen_valid           = 1'b1;
				gen_beat.reg_select = 1'b1;
				gen_beat.from_store = 1'b1;
				gen_beat.last       = row_last && col_last;
			end
			default: begin
				gen_valid = 1'b0;
			end
		endcase
	end

	// Next state and counter updates.
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		col_d   = col_q;
		row_d   = row_q;
		case (state_q)
			clrs_pkg::SEQ_IDLE: begin
				if (gen_fire && q_head.op == clrs_pkg::CMD_INIT) begin
					state_d = clrs_pkg::SEQ_INIT;
					idx_d   = 3'd1;
				end else if (gen_fire && q_head.op == clrs_pkg::CMD_REFRESH) begin
					state_d = clrs_pkg::SEQ_DATA;
					row_d   = '0;
					col_d   = '0;
				end
			end
			clrs_pkg::SEQ_INIT: begin
				if (gen_fire) begin
					idx_d = idx_q + 3'd1;
					if (gen_beat.last) begin
						state_d = clrs_pkg::SEQ_IDLE;
					end
				end
			end
			clrs_pkg::SEQ_ROWCMD: begin
				if (gen_fire) begin
					state_d = clrs_pkg::SEQ_DATA;
					col_d   = '0;
				end
			end
			clrs_pkg::SEQ_DATA: begin
				if (gen_fire) begin
					col_d = col_q + CW'(1);
					if (col_last) begin
						if (row_last) begin
							state_d = clrs_pkg::SEQ_IDLE;
						end else begin
							state_d = clrs_pkg::SEQ_ROWCMD;
							row_d   = row_q + RW'(1);
						end
					end
				end
			end
			default: begin
				state_d = clrs_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clrs_pkg::SEQ_IDLE;
			idx_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			col_q   <= col_d;
			row_q   <= row_d;
		end
	end

	// Frame store; the read address holds while a store beat waits in stage one.
	assign rd_addr = gen_fire ? gen_addr : addr_s1;

	clrs_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_head.addr[AW-1:0]),
		.wdata(q_head.data),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// Per-entry written bits; an unwritten entry reads as blank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[q_head.addr[AW-1:0]] <= 1'b1;
		end
	end

	// Stage one waits for the store read data.
	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign s1_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= gen_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_fire) begin
			beat_s1 <= gen_beat;
			addr_s1 <= gen_addr;
		end
	end

	// Text ends at the first zero byte of a row; spaces fill the rest.
	assign store_byte = valid_q[addr_s1] ? ram_rdata : 8'h00;
	assign ended_d    = beat_s1.from_store && (ended_q || (store_byte == 8'h00));

	always_comb begin
		out_next.reg_select = beat_s1.reg_select;
		out_next.last       = beat_s1.last;
		if (beat_s1.from_store) begin
			out_next.bus_byte = ended_d ? clrs_pkg::SPACE_CHAR : store_byte;
		end else begin
			out_next.bus_byte = beat_s1.bus_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ended_q     <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
			ended_q     <= ended_d;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A held store beat keeps its read address, so its data survives the stall.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |-> (rd_addr == addr_s1))
		else $error("store read address moved under a held beat");
	// A control beat on the bus always restarts the row text.
	assert property (@(posedge clk) disable iff (!arst_n)
		($past(s1_adv) && !out_q.reg_select) |-> !ended_q)
		else $error("end-of-text flag not cleared by a control beat");
	// The final data beat of a refresh returns the sequencer to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(gen_fire && state_q == clrs_pkg::SEQ_DATA && gen_beat.last)
		|=> state_q == clrs_pkg::SEQ_IDLE)
		else $error("sequencer did not return to idle after a refresh");

endmodule

@@ src/char_lcd_refresh_sequencer.sv @@
// Top level of the character LCD refresh sequencer.
//
//  Channel         Direction  Handshake              Beat
//  in              input      in_valid / in_stall    in_item_t: opcode, row, column, char_code
//  out             output     out_valid / out_stall  out_item_t: reg_select, bus_byte, last
//  refresh_period  input      refresh_period_we      16-bit period, write only
//
// A refresh sends ROWS * (COLUMNS + 1) bus writes at one per cycle while the bus does not
// stall, from the store's single read port, 34 writes at the default 2 x 16 geometry;
// init sends 6, set cursor sends 1. Write char is done by the back end while idle, waiting
// while a store beat is held for the bus; input beats are taken while the 4-entry command
// queue has room, so they keep arriving while the back end streams.
// Reset clears the store at once through per-entry written bits; there is no clearing pass.
// Output stalls hold the beat in the output register and back up into the queue.
module char_lcd_refresh_sequencer #(
	parameter int ROWS    = clrs_pkg::ROWS_DEFAULT,
	parameter int COLUMNS = clrs_pkg::COLUMNS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  clrs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output clrs_pkg::out_item_t out_data,
	input  logic                refresh_period_we,
	input  logic [15:0]         refresh_period_wdata
);

	logic [15:0]    refresh_period_q;
	logic           push;
	clrs_pkg::cmd_t push_cmd;
	logic           q_full;
	logic           q_pop;
	logic           q_not_empty;
	clrs_pkg::cmd_t q_head;

	// Refresh period register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_period_q <= clrs_pkg::PERIOD_RESET;
		end else if (refresh_period_we) begin
			refresh_period_q <= refresh_period_wdata;
		end
	end

	clrs_front #(
		.ROWS   (ROWS),
		.COLUMNS(COLUMNS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.refresh_period(refresh_period_q),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	clrs_queue #(
		.DEPTH(clrs_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	clrs_back #(
		.ROWS   (ROWS),
		.COLUMNS(COLUMNS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
